### rtl/itf_pkg.sv
// Package for the integer text formatter: constants, flag positions and the
// transaction type passed from the digit front end to the character back end.
// No dependencies.
`timescale 1ns / 1ps
package itf_pkg;

   localparam int BUFFER_DEPTH = 32;
   localparam int MAX_WIDTH    = 63;
   localparam int PREC_LIMIT   = 32;
   localparam int MAX_RESULTS  = 63;
   localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int CNT_W        = 6;

   localparam int FL_ZEROPAD   = 0;
   localparam int FL_LEFT      = 1;
   localparam int FL_PLUS      = 2;
   localparam int FL_SPACE     = 3;
   localparam int FL_ALT       = 4;
   localparam int FL_UPPER     = 5;
   localparam int FL_PRECGIVEN = 6;

   localparam logic [1:0] BASE_BIN = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_DEC = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_LA    = 8'h61;

   typedef struct packed {
      logic [BUFFER_DEPTH-1:0][7:0] buf_chars;
      logic [LEN_W-1:0]             len;
      logic [CNT_W-1:0]             lead_pad;
      logic [CNT_W-1:0]             trail_pad;
   } itf_field_type;

endpackage

### rtl/itf_front.sv
// Front end: accepts a transaction, extracts digits (one a cycle in binary, octal
// and hex; in decimal each digit passes S_DIV_A and S_DIV_B first) and builds the
// character buffer with zeros, prefix and sign. Depends on itf_pkg.
`timescale 1ns / 1ps
module itf_front import itf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [63:0]   req_magnitude,
   input  logic          req_is_negative,
   input  logic [1:0]    req_base_sel,
   input  logic [5:0]    req_min_digits,
   input  logic [5:0]    req_field_width,
   input  logic [6:0]    req_format_flags,
   output logic          fq_valid,
   input  logic          fq_stall,
   output itf_field_type fq_data
);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV_A, S_DIV_B, S_DIGIT, S_FILL, S_FINISH, S_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [63:0]                  val_ff, val_in;
   logic                         neg_ff, neg_in;
   logic [1:0]                   base_ff, base_in;
   logic [5:0]                   prec_ff, prec_in;
   logic [5:0]                   width_ff, width_in;
   logic [6:0]                   flags_ff, flags_in;
   logic [BUFFER_DEPTH-1:0][7:0] buf_ff, buf_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   itf_field_type                out_ff, out_in;
   logic                         alt_flag_ff, alt_flag_in;

   logic [3:0]  digit;
   logic [63:0] quot;
   logic        has_sign;
   logic [5:0]  wz;
   logic [LEN_W-1:0] l;
   logic [6:0]  total;

   // Decimal digits divide by ten with a shift-and-add estimate of 0.8 times the
   // value, spread over S_DIV_A and S_DIV_B, then a low-bit remainder check
   // corrects the quotient by at most one.
   logic [63:0] q_ff, q_in;
   logic [63:0] est1, est2, est3, est4, est5;
   logic [4:0]  rem5;
   logic        fix;

   assign est1 = {1'b0, val_ff[63:1]} + {2'b00, val_ff[63:2]};
   assign est2 = est1 + {4'd0, est1[63:4]};
   assign est3 = est2 + {8'd0, est2[63:8]};
   assign est4 = q_ff + {16'd0, q_ff[63:16]};
   assign est5 = est4 + {32'd0, est4[63:32]};
   assign rem5 = val_ff[4:0] - ({q_ff[1:0], 3'b000} + {q_ff[3:0], 1'b0});
   assign fix  = (rem5 >= 5'd10);

   always_comb begin
      case (base_ff)
         BASE_BIN: begin digit = {3'd0, val_ff[0]};  quot = {1'b0, val_ff[63:1]}; end
         BASE_OCT: begin digit = {1'b0, val_ff[2:0]}; quot = {3'd0, val_ff[63:3]}; end
         BASE_HEX: begin digit = val_ff[3:0];        quot = {4'd0, val_ff[63:4]}; end
         default:  begin
            digit = fix ? 4'(rem5 - 5'd10) : rem5[3:0];
            quot  = q_ff + {63'd0, fix};
         end
      endcase
   end

   assign has_sign = neg_ff | flags_ff[FL_PLUS] | flags_ff[FL_SPACE];

   always_comb begin
      state_in = state_ff;
      val_in = val_ff; neg_in = neg_ff; base_in = base_ff; prec_in = prec_ff;
      width_in = width_ff; flags_in = flags_ff; buf_in = buf_ff; len_in = len_ff;
      out_in = out_ff; q_in = q_ff;
      wz = '0; l = len_ff; total = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in   = req_magnitude;
               neg_in   = req_is_negative;
               base_in  = req_base_sel;
               prec_in  = (req_min_digits > 6'(PREC_LIMIT)) ? 6'(PREC_LIMIT) : req_min_digits;
               width_in = (req_field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req_field_width;
               flags_in = req_format_flags;
               len_in   = '0;
               q_in     = '0;
               if (req_format_flags[FL_PRECGIVEN] && req_magnitude == 64'd0)
                  state_in = S_FILL;
               else if (req_base_sel == BASE_DEC)
                  state_in = S_DIV_A;
               else
                  state_in = S_DIGIT;
            end
         end
         S_DIV_A: begin
            q_in     = est3;
            state_in = S_DIV_B;
         end
         S_DIV_B: begin
            q_in     = {3'd0, est5[63:3]};
            state_in = S_DIGIT;
         end
         S_DIGIT: begin
            buf_in[len_ff[IDX_W-1:0]] = (digit < 4'd10) ? CH_ZERO + 8'(digit)
               : (flags_ff[FL_UPPER] ? CH_UA : CH_LA) + 8'(digit) - 8'd10;
            len_in = len_ff + LEN_W'(1);
            val_in = quot;
            if (quot == 64'd0 || len_in == LEN_W'(BUFFER_DEPTH))
               state_in = S_FILL;
            else if (base_ff == BASE_DEC)
               state_in = S_DIV_A;
         end
         S_FILL: begin
            // One zero per cycle; precision zeros then zero padding.
            wz = (width_ff != 6'd0 && flags_ff[FL_ZEROPAD] && has_sign)
                 ? width_ff - 6'd1 : width_ff;
            if (!flags_ff[FL_LEFT] && len_ff < LEN_W'(BUFFER_DEPTH) &&
                (7'(len_ff) < 7'(prec_ff) ||
                 (flags_ff[FL_ZEROPAD] && 7'(len_ff) < 7'(wz)))) begin
               buf_in[len_ff[IDX_W-1:0]] = CH_ZERO;
               len_in = len_ff + LEN_W'(1);
            end else begin
               width_in = flags_ff[FL_LEFT] ? width_ff : wz;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            l = len_ff;
            if (alt_flag_ff) begin
               if (!flags_ff[FL_PRECGIVEN] && l != '0 &&
                   (7'(l) == 7'(prec_ff) || 7'(l) == 7'(width_ff))) begin
                  l = l - LEN_W'(1);
                  if (l != '0 && base_ff == BASE_HEX) l = l - LEN_W'(1);
               end
               if (base_ff == BASE_HEX && l < LEN_W'(BUFFER_DEPTH)) begin
                  buf_in[l[IDX_W-1:0]] = flags_ff[FL_UPPER] ? CH_UX : CH_LX;
                  l = l + LEN_W'(1);
               end else if (base_ff == BASE_BIN && l < LEN_W'(BUFFER_DEPTH)) begin
                  buf_in[l[IDX_W-1:0]] = CH_LB;
                  l = l + LEN_W'(1);
               end
               if (l < LEN_W'(BUFFER_DEPTH)) begin
                  buf_in[l[IDX_W-1:0]] = CH_ZERO;
                  l = l + LEN_W'(1);
               end
            end
            if (l < LEN_W'(BUFFER_DEPTH) && has_sign) begin
               buf_in[l[IDX_W-1:0]] = neg_ff ? CH_MINUS
                                   : (flags_ff[FL_PLUS] ? CH_PLUS : CH_SPACE);
               l = l + LEN_W'(1);
            end
            len_in = l;
            out_in.buf_chars = buf_in;
            out_in.len = l;
            out_in.lead_pad = (!flags_ff[FL_LEFT] && !flags_ff[FL_ZEROPAD] &&
                               7'(l) < 7'(width_ff)) ? CNT_W'(7'(width_ff) - 7'(l)) : '0;
            total = 7'(l);
            if (total > 7'(MAX_RESULTS)) total = 7'(MAX_RESULTS);
            out_in.trail_pad = (flags_ff[FL_LEFT] && total < 7'(width_ff))
                               ? CNT_W'(7'(width_ff) - total) : '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!fq_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Alternate form is kept only for a nonzero value in a non-decimal radix.
   always_comb begin
      alt_flag_in = alt_flag_ff;
      if (state_ff == S_IDLE && req_valid)
         alt_flag_in = req_format_flags[FL_ALT] && req_base_sel != BASE_DEC &&
                       req_magnitude != 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff <= val_in; neg_ff <= neg_in; base_ff <= base_in; prec_ff <= prec_in;
      width_ff <= width_in; flags_ff <= flags_in; buf_ff <= buf_in; len_ff <= len_in;
      out_ff <= out_in; q_ff <= q_in;
      alt_flag_ff <= alt_flag_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign fq_valid  = (state_ff == S_OUT);
   assign fq_data   = out_ff;

endmodule

### rtl/itf_back.sv
// Back end: takes a built field and emits padding and buffered characters,
// one character per cycle while rsp_stall is low. Depends on itf_pkg.
`timescale 1ns / 1ps
module itf_back import itf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          fq_valid,
   output logic          fq_stall,
   input  itf_field_type fq_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_char_out,
   output logic          rsp_last_char
);

   logic                busy_ff, busy_in;
   itf_field_type       fld_ff, fld_in;
   logic [CNT_W-1:0]    lead_ff, lead_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    trail_ff, trail_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                ov_ff, ov_in;
   logic [7:0]          ch_ff, ch_in;
   logic                last_ff, last_in;
   logic [7:0]          ch;
   logic                fin;
   logic                take;
   logic                space_ok;

   assign space_ok = !ov_ff || !rsp_stall;
   assign take     = fq_valid && !busy_ff;
   assign fq_stall = busy_ff;

   always_comb begin
      busy_in = busy_ff; fld_in = fld_ff; lead_in = lead_ff; pos_in = pos_ff;
      trail_in = trail_ff; cnt_in = cnt_ff; ov_in = ov_ff && rsp_stall;
      ch_in = ch_ff; last_in = last_ff; ch = CH_SPACE; fin = 1'b0;
      if (take) begin
         fld_in = fq_data; lead_in = fq_data.lead_pad; pos_in = fq_data.len;
         trail_in = fq_data.trail_pad; cnt_in = '0;
         busy_in = (fq_data.lead_pad != '0) || (fq_data.len != '0) ||
                   (fq_data.trail_pad != '0);
      end else if (busy_ff && space_ok) begin
         if (lead_ff != '0) begin
            lead_in = lead_ff - CNT_W'(1);
         end else if (pos_ff != '0) begin
            ch = fld_ff.buf_chars[IDX_W'(pos_ff - LEN_W'(1))];
            pos_in = pos_ff - LEN_W'(1);
         end else begin
            trail_in = trail_ff - CNT_W'(1);
         end
         cnt_in = cnt_ff + CNT_W'(1);
         fin = (cnt_in == CNT_W'(MAX_RESULTS)) ||
               (lead_in == '0 && pos_in == '0 && trail_in == '0);
         if (fin) busy_in = 1'b0;
         ov_in = 1'b1; ch_in = ch; last_in = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
      end
      fld_ff <= fld_in; lead_ff <= lead_in; pos_ff <= pos_in; trail_ff <= trail_in;
      cnt_ff <= cnt_in; ch_ff <= ch_in; last_ff <= last_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_char_out  = ch_ff;
   assign rsp_last_char = last_ff;

endmodule

### rtl/integer_text_formatter_top.sv
// Integer text formatter top: front end builds the field, back end streams it.
// The first character follows the front end's digit steps (in decimal, each digit also passes
// S_DIV_A and S_DIV_B), its precision and padding zeros, and its prefix and sign step.
// Throughput: one character per cycle within a field while rsp_stall is low; the front end
// works on the next transaction while the back end streams. Synchronous active-high reset
// empties both ends.
`timescale 1ns / 1ps
module integer_text_formatter_top import itf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_magnitude,
   input  logic        req_is_negative,
   input  logic [1:0]  req_base_sel,
   input  logic [5:0]  req_min_digits,
   input  logic [5:0]  req_field_width,
   input  logic [6:0]  req_format_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last_char
);

   logic          fq_valid;
   logic          fq_stall;
   itf_field_type fq_data;

   itf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_magnitude, .req_is_negative,
      .req_base_sel, .req_min_digits, .req_field_width, .req_format_flags,
      .fq_valid, .fq_stall, .fq_data
   );

   itf_back u_back (
      .clock, .reset, .fq_valid, .fq_stall, .fq_data,
      .rsp_valid, .rsp_stall, .rsp_char_out, .rsp_last_char
   );

endmodule

### tb/sv/tb_integer_text_formatter_top.sv
// Self-checking testbench for integer_text_formatter_top: directed table, then random
// transactions, with every character checked against a directed row's text or a built-in
// printf-style predictor. Depends on itf_pkg and the formatter RTL.
`timescale 1ns / 1ps
module tb_integer_text_formatter_top;
   import itf_pkg::*;

   localparam logic [6:0] F_ZP   = 7'(1 << FL_ZEROPAD);
   localparam logic [6:0] F_LEFT = 7'(1 << FL_LEFT);
   localparam logic [6:0] F_PLUS = 7'(1 << FL_PLUS);
   localparam logic [6:0] F_SPC  = 7'(1 << FL_SPACE);
   localparam logic [6:0] F_ALT  = 7'(1 << FL_ALT);
   localparam logic [6:0] F_UP   = 7'(1 << FL_UPPER);
   localparam logic [6:0] F_PREC = 7'(1 << FL_PRECGIVEN);
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      logic [63:0] mag;
      logic        neg;
      logic [1:0]  base;
      logic [5:0]  prec;
      logic [5:0]  width;
      logic [6:0]  flags;
      bit          typed;
      string       text;
   } number_row_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_exp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_magnitude;
   logic        req_is_negative;
   logic [1:0]  req_base_sel;
   logic [5:0]  req_min_digits;
   logic [5:0]  req_field_width;
   logic [6:0]  req_format_flags;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_char_out;
   logic        rsp_last_char;

   char_exp_type pending_chars[$];
   int          error_count = 0;
   bit          quiet = 0;
   bit          hold_req = 0;
   bit          hold_taken = 0;
   int          hold_left = 0;

   integer_text_formatter_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_integer_text_formatter_top NOT OK");
      $finish;
   end

   function automatic void format_number(input number_row_type r, ref logic [7:0] txt[$]);
      logic [7:0]  digs[BUFFER_DEPTH];
      logic [63:0] v;
      logic [63:0] radix;
      int          len;
      int          prec;
      int          width;
      int          d;
      bit          zp;
      bit          left;
      bit          alt;
      bit          pgiven;
      bit          upper;
      bit          has_sign;
      v = r.mag;
      len = 0;
      case (r.base)
         BASE_BIN: radix = 2;
         BASE_OCT: radix = 8;
         BASE_DEC: radix = 10;
         default:  radix = 16;
      endcase
      prec = (r.prec > PREC_LIMIT) ? PREC_LIMIT : r.prec;
      width = (r.width > MAX_WIDTH) ? MAX_WIDTH : r.width;
      zp = r.flags[FL_ZEROPAD];
      left = r.flags[FL_LEFT];
      alt = r.flags[FL_ALT];
      pgiven = r.flags[FL_PRECGIVEN];
      upper = r.flags[FL_UPPER];
      has_sign = r.neg || r.flags[FL_PLUS] || r.flags[FL_SPACE];
      if (v == 0 || radix == 10) alt = 0;
      if (!pgiven || v != 0) begin
         do begin
            d = int'(v % radix);
            digs[len] = (d < 10) ? 8'(CH_ZERO + d) : 8'((upper ? CH_UA : CH_LA) + d - 10);
            len++;
            v = v / radix;
         end while (v != 0 && len < BUFFER_DEPTH);
      end
      if (!left) begin
         if (width != 0 && zp && has_sign) width--;
         while (len < prec && len < BUFFER_DEPTH) begin
            digs[len] = CH_ZERO;
            len++;
         end
         while (zp && len < width && len < BUFFER_DEPTH) begin
            digs[len] = CH_ZERO;
            len++;
         end
      end
      if (alt) begin
         if (!pgiven && len != 0 && (len == prec || len == width)) begin
            len--;
            if (len != 0 && radix == 16) len--;
         end
         if (radix == 16 && len < BUFFER_DEPTH) begin
            digs[len] = upper ? CH_UX : CH_LX;
            len++;
         end else if (radix == 2 && len < BUFFER_DEPTH) begin
            digs[len] = CH_LB;
            len++;
         end
         if (len < BUFFER_DEPTH) begin
            digs[len] = CH_ZERO;
            len++;
         end
      end
      if (len < BUFFER_DEPTH) begin
         if (r.neg) begin
            digs[len] = CH_MINUS;
            len++;
         end else if (r.flags[FL_PLUS]) begin
            digs[len] = CH_PLUS;
            len++;
         end else if (r.flags[FL_SPACE]) begin
            digs[len] = CH_SPACE;
            len++;
         end
      end
      if (!left && !zp)
         for (int i = len; i < width; i++) txt.push_back(CH_SPACE);
      while (len != 0) begin
         len--;
         txt.push_back(digs[len]);
      end
      if (left)
         while (txt.size() < width) txt.push_back(CH_SPACE);
      while (txt.size() > MAX_RESULTS) void'(txt.pop_back());
   endfunction

   task automatic send_number(input number_row_type r);
      logic [7:0] txt[$];
      if (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_magnitude <= r.mag;
      req_is_negative <= r.neg;
      req_base_sel <= r.base;
      req_min_digits <= r.prec;
      req_field_width <= r.width;
      req_format_flags <= r.flags;
      do @(posedge clock); while (req_stall);
      if (r.typed) begin
         for (int i = 0; i < r.text.len(); i++) txt.push_back(r.text[i]);
      end else begin
         format_number(r, txt);
      end
      foreach (txt[i]) pending_chars.push_back('{txt[i], i == txt.size() - 1});
   endtask

   function automatic number_row_type random_number();
      number_row_type r;
      case ($urandom_range(5))
         0: r.mag = 0;
         1: r.mag = 64'($urandom_range(1000));
         2: r.mag = {$urandom, $urandom};
         3: r.mag = 64'hFFFF_FFFF_FFFF_FFFF;
         4: r.mag = 64'd1 << $urandom_range(63);
         default: r.mag = 64'($urandom);
      endcase
      r.neg = 1'($urandom_range(1));
      r.base = 2'($urandom_range(3));
      r.prec = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
      r.width = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(16));
      r.flags = 7'($urandom_range(127));
      r.typed = 0;
      r.text = "";
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      char_exp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected character %h", rsp_char_out);
            error_count++;
         end else begin
            e = pending_chars.pop_front();
            if (rsp_char_out !== e.ch) begin
               $error("char_out expected %h actual %h", e.ch, rsp_char_out);
               error_count++;
            end
            if (rsp_last_char !== e.last) begin
               $error("last_char expected %b actual %b", e.last, rsp_last_char);
               error_count++;
            end
         end
      end
   end

   number_row_type directed[] = '{
      '{64'd0, 0, BASE_DEC, 6'd0, 6'd0, F_PREC, 1, ""},
      '{64'd0, 0, BASE_DEC, 6'd0, 6'd0, 7'd0, 1, "0"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 0, BASE_HEX, 6'd0, 6'd0, 7'd0, 1, "ffffffffffffffff"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 0, BASE_HEX, 6'd0, 6'd0, F_UP, 1, "FFFFFFFFFFFFFFFF"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 0, BASE_DEC, 6'd0, 6'd0, 7'd0, 1, "18446744073709551615"},
      '{64'd255, 0, BASE_HEX, 6'd0, 6'd0, F_ALT, 1, "0xff"},
      '{64'd255, 0, BASE_HEX, 6'd0, 6'd0, F_ALT | F_UP, 1, "0XFF"},
      '{64'd5, 0, BASE_BIN, 6'd0, 6'd0, F_ALT, 1, "0b101"},
      '{64'd8, 0, BASE_OCT, 6'd0, 6'd0, F_ALT, 1, "010"},
      '{64'd42, 1, BASE_DEC, 6'd0, 6'd0, 7'd0, 1, "-42"},
      '{64'd42, 0, BASE_DEC, 6'd0, 6'd0, F_PLUS, 1, "+42"},
      '{64'd42, 0, BASE_DEC, 6'd0, 6'd0, F_SPC, 1, " 42"},
      '{64'd42, 0, BASE_DEC, 6'd0, 6'd6, 7'd0, 1, "    42"},
      '{64'd42, 0, BASE_DEC, 6'd0, 6'd6, F_LEFT, 1, "42    "},
      '{64'd42, 1, BASE_DEC, 6'd0, 6'd6, F_ZP, 1, "-00042"},
      '{64'd1, 0, BASE_DEC, 6'd5, 6'd0, F_PREC, 1, "00001"},
      '{64'd0, 0, BASE_HEX, 6'd0, 6'd0, F_ALT, 1, "0"},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1, BASE_BIN, 6'd0, 6'd0, F_ALT, 0, ""},
      '{64'hFFFF_FFFF_FFFF_FFFF, 0, BASE_OCT, 6'd0, 6'd63, F_LEFT | F_PLUS, 0, ""},
      '{64'd7, 0, BASE_DEC, 6'd63, 6'd63, F_PREC | F_ZP | F_PLUS, 0, ""},
      '{64'd255, 0, BASE_HEX, 6'd0, 6'd4, F_ALT | F_ZP, 0, ""},
      '{64'd255, 0, BASE_HEX, 6'd2, 6'd0, F_ALT, 0, ""},
      '{64'd0, 0, BASE_DEC, 6'd0, 6'd5, F_PREC | F_SPC, 0, ""},
      '{64'd9, 1, BASE_OCT, 6'd3, 6'd63, F_ZP | F_LEFT | F_ALT, 0, ""}
   };

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_magnitude <= '0;
      req_is_negative <= 1'b0;
      req_base_sel <= BASE_BIN;
      req_min_digits <= '0;
      req_field_width <= '0;
      req_format_flags <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_number(directed[i]);
      for (int n = 0; n < 210; n++) begin
         quiet = (n >= 60 && n < 110);
         if (n == 130) hold_req = 1;
         if (n == 170) begin
            req_valid <= 1'b0;
            wait (pending_chars.size() == 0);
            @(posedge clock);
         end
         send_number(random_number());
      end
      req_valid <= 1'b0;
      wait (pending_chars.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_chars.size() == 0) begin
         $display("tb_integer_text_formatter_top OK");
      end else begin
         $display("tb_integer_text_formatter_top NOT OK");
      end
      $finish;
   end

endmodule

### integer_text_formatter_top.f
rtl/itf_pkg.sv
rtl/itf_front.sv
rtl/itf_back.sv
rtl/integer_text_formatter_top.sv
tb/sv/tb_integer_text_formatter_top.sv
